[hw/rtl/cws_pkg.sv]
// Shared types and character codes for the comment and whitespace stripper.
// No dependencies; the stripper top, cws_lexer and cws_out_queue import this package.
`default_nettype none

package cws_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Result queue depth and its count width
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned CNT_W       = 2;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       error;
  } result_t;

  // Results of one lexer step, in output order
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
  } lex_out_t;

endpackage

`default_nettype wire

[hw/rtl/cws_text_if.sv]
// Input channel of the stripper: one source byte and its end mark per transfer.
// Standalone interface; no package needed.
`default_nettype none

interface cws_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/cws_result_if.sv]
// Output channel of the stripper: one kept byte or end marker per transfer.
// Standalone interface; no package needed.
`default_nettype none

interface cws_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       error;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  input error, output ready);
endinterface

`default_nettype wire

[hw/rtl/comment_whitespace_stripper.sv]
// Comment and whitespace stripper for C-style script source.
// Channels: text (sink) takes in_byte with in_last marking the final byte of
// the source; result (source) gives out_byte, byte_valid, out_last and error.
// A transfer happens when valid and ready are both high at a clock edge.
// A byte's first result passes through the input register, then the lexer step
// writes it into the result queue, whose head drives the result channel.
// Throughput: one byte per cycle. A byte yields zero, one or two results; the
// result channel moves one per cycle, so a run of two-result bytes fills the
// three-entry queue and text.ready then drops until space frees.
// The end of the text always yields a result with out_last set: on the last
// kept character, or as a bare marker with byte_valid low; error on it reports
// an open quote or block comment.
// When the receiver stalls, queued results hold and text.ready does not depend
// on result.ready. Reset (rst, synchronous) empties the input register and the
// queue and returns the lexer to normal text.
// Depends on cws_pkg, cws_text_if, cws_result_if, cws_lexer and cws_out_queue.
`default_nettype none

module comment_whitespace_stripper import cws_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  cws_text_if.sink     text,
  cws_result_if.source result
);

  logic             in_v;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             advance;
  logic [CNT_W-1:0] room;
  lex_out_t         lex_res;

  // Advance the held byte only when all its results fit
  assign advance    = in_v && ({1'b0, lex_res.n} <= {1'b0, room});
  assign text.ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte_q <= text.in_byte;
      in_last_q <= text.in_last;
    end
  end

  cws_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (in_byte_q),
    .last (in_last_q),
    .res  (lex_res)
  );

  cws_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_n  (advance ? lex_res.n : 2'd0),
    .push_r0 (lex_res.r0),
    .push_r1 (lex_res.r1),
    .room    (room),
    .result  (result)
  );

endmodule

`default_nettype wire

[hw/rtl/cws_lexer.sv]
// Lexer state and per-byte decode: yields up to two results for one source byte.
// Depends on cws_pkg for modes, character codes and result types.
`default_nettype none

module cws_lexer import cws_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  output lex_out_t        res
);

  lex_mode_t mode, mode_next;
  logic      quote_is_double, quote_is_double_next;
  logic      escape_pending, escape_pending_next;
  logic      slash_pending, slash_pending_next;
  logic      star_seen, star_seen_next;

  logic is_quote, is_ws, is_slash, is_star, is_close;
  logic keep_normal, emit_slash_first, emit_ch, emit_end_slash;

  assign is_slash = (ch == CH_SLASH);
  assign is_star  = (ch == CH_STAR);
  assign is_quote = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
  assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
  assign is_close = quote_is_double ? (ch == CH_DQUOTE) : (ch == CH_SQUOTE);

  // A held slash that does not open a comment goes out ahead of this byte
  assign keep_normal      = is_quote || (!is_slash && !is_ws);
  assign emit_slash_first = (mode == MODE_NORMAL) && slash_pending && !is_slash && !is_star;
  assign emit_ch          = (mode == MODE_QUOTE) ||
                            ((mode == MODE_NORMAL) && keep_normal &&
                             (!slash_pending || (!is_slash && !is_star)));
  assign emit_end_slash   = last && (mode == MODE_NORMAL) && !slash_pending && is_slash;

  // Next state
  always_comb begin
    mode_next            = mode;
    quote_is_double_next = quote_is_double;
    escape_pending_next  = escape_pending;
    slash_pending_next   = slash_pending;
    star_seen_next       = star_seen;
    case (mode)
      MODE_QUOTE: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (ch == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (is_close) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (ch == CH_LF) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (star_seen && is_slash) begin
          mode_next      = MODE_NORMAL;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = is_star;
        end
      end
      default: begin
        if (slash_pending && is_slash) begin
          slash_pending_next = 1'b0;
          mode_next          = MODE_LINE;
        end else if (slash_pending && is_star) begin
          slash_pending_next = 1'b0;
          mode_next          = MODE_BLOCK;
          star_seen_next     = 1'b0;
        end else begin
          slash_pending_next = 1'b0;
          if (is_quote) begin
            mode_next            = MODE_QUOTE;
            quote_is_double_next = (ch == CH_DQUOTE);
            escape_pending_next  = 1'b0;
          end else if (is_slash) begin
            slash_pending_next = 1'b1;
          end
        end
      end
    endcase
    // The final byte closes the text
    if (last) begin
      mode_next            = MODE_NORMAL;
      quote_is_double_next = 1'b0;
      escape_pending_next  = 1'b0;
      slash_pending_next   = 1'b0;
      star_seen_next       = 1'b0;
    end
  end

  // Outputs
  always_comb begin
    logic       err;
    logic [1:0] nchar;
    err   = 1'b0;
    nchar = 2'(emit_slash_first) + 2'(emit_ch) + 2'(emit_end_slash);

    res.r0.out_byte   = emit_slash_first ? CH_SLASH : (emit_ch ? ch : CH_SLASH);
    res.r0.byte_valid = 1'b1;
    res.r0.out_last   = 1'b0;
    res.r0.error      = 1'b0;
    res.r1.out_byte   = ch;
    res.r1.byte_valid = 1'b1;
    res.r1.out_last   = 1'b0;
    res.r1.error      = 1'b0;
    res.n             = nchar;

    if (last) begin
      // Error reflects the mode after this byte
      case (mode)
        MODE_QUOTE: err = !(escape_pending == 1'b0 && ch != CH_BSLASH && is_close);
        MODE_BLOCK: err = !(star_seen && is_slash);
        MODE_LINE:  err = 1'b0;
        default:    err = (slash_pending && is_star) || (!slash_pending && is_quote) ||
                          (slash_pending && !is_slash && !is_star && is_quote);
      endcase
      if (nchar == 2'd0) begin
        res.r0.out_byte   = 8'h00;
        res.r0.byte_valid = 1'b0;
        res.r0.out_last   = 1'b1;
        res.r0.error      = err;
        res.n             = 2'd1;
      end else if (nchar == 2'd1) begin
        res.r0.out_last = 1'b1;
        res.r0.error    = err;
      end else begin
        res.r1.out_last = 1'b1;
        res.r1.error    = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      quote_is_double <= 1'b0;
      escape_pending  <= 1'b0;
      slash_pending   <= 1'b0;
      star_seen       <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      quote_is_double <= quote_is_double_next;
      escape_pending  <= escape_pending_next;
      slash_pending   <= slash_pending_next;
      star_seen       <= star_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_two_are_chars: assert property (@(posedge clk) disable iff (rst)
    (step && res.n == 2'd2) |-> (res.r0.byte_valid && res.r1.byte_valid && !res.r0.out_last))
    else $error("two results from one byte must both carry characters");
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (mode == MODE_NORMAL && !slash_pending && !escape_pending))
    else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire

[hw/rtl/cws_out_queue.sv]
// Three-entry ordered result queue between the lexer and the result channel.
// Depends on cws_pkg for result types and queue sizing; drives cws_result_if.
`default_nettype none

module cws_out_queue import cws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  push_n,
  input  wire result_t     push_r0,
  input  wire result_t     push_r1,
  output logic [CNT_W-1:0] room,
  cws_result_if.source     result
);

  result_t          q [QUEUE_DEPTH];
  result_t          q_next [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt, cnt_next, cnt_pop;
  logic             pop;

  assign room = CNT_W'(QUEUE_DEPTH) - cnt;
  assign pop  = (cnt != '0) && result.ready;

  assign result.valid      = (cnt != '0);
  assign result.out_byte   = q[0].out_byte;
  assign result.byte_valid = q[0].byte_valid;
  assign result.out_last   = q[0].out_last;
  assign result.error      = q[0].error;

  // Shift out the head on a transfer, then append behind the survivors
  always_comb begin
    cnt_pop  = cnt - CNT_W'(pop);
    cnt_next = cnt_pop + CNT_W'(push_n);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        q_next[i] = q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end else begin
        q_next[i] = q[i];
      end
      if (CNT_W'(i) == cnt_pop && push_n != 2'd0) begin
        q_next[i] = push_r0;
      end else if (CNT_W'(i) == cnt_pop + CNT_W'(1) && push_n == 2'd2) begin
        q_next[i] = push_r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ({1'b0, push_n} <= {1'b0, room}))
    else $error("result queue overflow");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && cnt >= $past(cnt)))
    else $error("result lost while receiver stalled");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for comment_whitespace_stripper: short texts go in, compacted text comes out.
// A scoreboard class predicts each result from the accepted bytes; the driver and receiver
// idle at random. Depends on cws_pkg, cws_text_if, cws_result_if and the RTL top.
`default_nettype none

module tb_top;
  import cws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BYTES = 650;
  localparam int PHASES       = 4;
  localparam int SETTLE       = 8;
  localparam int MAX_PRINTS   = 60;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } src_byte_t;

  // Predicts what the stripper keeps and checks each result transfer against it.
  class strip_scoreboard;
    lex_mode_t  mode;
    logic       in_dquote;
    logic       esc_pending;
    logic       slash_held;
    logic       star_seen;
    result_t    step_results[$];
    result_t    expected_results[$];
    int         errors;
    int         checked;

    function new();
      clear_lexer();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_lexer();
      mode        = MODE_NORMAL;
      in_dquote   = 1'b0;
      esc_pending = 1'b0;
      slash_held  = 1'b0;
      star_seen   = 1'b0;
    endfunction

    function void keep(logic [7:0] ch);
      result_t r;
      r = '{out_byte: ch, byte_valid: 1'b1, out_last: 1'b0, error: 1'b0};
      step_results = {step_results, r};
    endfunction

    function void plain_char(logic [7:0] ch);
      if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
        mode        = MODE_QUOTE;
        in_dquote   = (ch == CH_DQUOTE);
        esc_pending = 1'b0;
        keep(ch);
      end else if (ch == CH_SLASH) begin
        slash_held = 1'b1;
      end else if (ch != CH_SPACE && ch != CH_TAB && ch != CH_CR && ch != CH_LF) begin
        keep(ch);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_byte(logic [7:0] ch, logic last);
      logic    open_err;
      result_t marker;
      step_results.delete();
      case (mode)
        MODE_QUOTE: begin
          keep(ch);
          if (esc_pending) esc_pending = 1'b0;
          else if (ch == CH_BSLASH) esc_pending = 1'b1;
          else if (ch == (in_dquote ? CH_DQUOTE : CH_SQUOTE)) mode = MODE_NORMAL;
        end
        MODE_LINE: begin
          if (ch == CH_LF) mode = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (star_seen && ch == CH_SLASH) begin
            mode      = MODE_NORMAL;
            star_seen = 1'b0;
          end else begin
            star_seen = (ch == CH_STAR);
          end
        end
        default: begin
          if (slash_held) begin
            slash_held = 1'b0;
            if (ch == CH_SLASH) begin
              mode = MODE_LINE;
            end else if (ch == CH_STAR) begin
              mode      = MODE_BLOCK;
              star_seen = 1'b0;
            end else begin
              keep(CH_SLASH);
              plain_char(ch);
            end
          end else begin
            plain_char(ch);
          end
        end
      endcase
      if (last) begin
        open_err = (mode == MODE_QUOTE || mode == MODE_BLOCK);
        if (slash_held) keep(CH_SLASH);
        if (step_results.size() == 0) begin
          marker = '{out_byte: 8'h00, byte_valid: 1'b0, out_last: 1'b0, error: 1'b0};
          step_results = {step_results, marker};
        end
        // end mark rides on the last result of this step
        step_results[step_results.size() - 1].out_last = 1'b1;
        step_results[step_results.size() - 1].error    = open_err;
        clear_lexer();
      end
      expected_results = {expected_results, step_results};
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result byte=%h byte_valid=%b out_last=%b error=%b",
                         got.out_byte, got.byte_valid, got.out_last, got.error));
        return;
      end
      want = expected_results.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("result %0d out_byte %h, want %h", checked, got.out_byte,
                         want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("result %0d byte_valid %b, want %b", checked, got.byte_valid,
                         want.byte_valid));
      if (got.out_last !== want.out_last)
        report($sformatf("result %0d out_last %b, want %b", checked, got.out_last,
                         want.out_last));
      if (got.error !== want.error)
        report($sformatf("result %0d error %b, want %b", checked, got.error, want.error));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  cws_text_if   text_ch ();
  cws_result_if result_ch ();

  comment_whitespace_stripper u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  strip_scoreboard sb = new();
  src_byte_t       src_q[$];
  int              queued_cnt   = 0;
  int              accepted_cnt = 0;
  int              idle_pct     = 0;
  int              stall_pct    = 0;
  bit              hold_req     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic queue_byte(logic [7:0] ch, logic last);
    src_byte_t item;
    item  = '{ch: ch, last: last};
    src_q = {src_q, item};
    queued_cnt++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] letter();
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  // Build one source text from tokens, mostly well formed, and queue it.
  task automatic queue_random_text(inout int count);
    logic [7:0] txt[$];
    logic [7:0] q;
    logic [7:0] b;
    int         n_tok;
    int         kind;
    int         len;
    int         r;
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        len = $urandom_range(1, 4);
        repeat (len) txt = {txt, letter()};
      end else if (kind < 40) begin
        case ($urandom_range(3))
          0:       txt = {txt, CH_SPACE};
          1:       txt = {txt, CH_TAB};
          2:       txt = {txt, CH_CR};
          default: txt = {txt, CH_LF};
        endcase
      end else if (kind < 48) begin
        txt = {txt, CH_SLASH};
        txt = {txt, ($urandom_range(1) ? letter() : CH_SPACE)};
      end else if (kind < 65) begin
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        txt = {txt, q};
        len = $urandom_range(0, 5);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 20) begin
            txt = {txt, CH_BSLASH};
            txt = {txt, ($urandom_range(1) ? q : 8'($urandom_range(255)))};
          end else if (r < 30) begin
            txt = {txt, (q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE)};
          end else begin
            b = 8'($urandom_range(255));
            txt = {txt, ((b == q || b == CH_BSLASH) ? letter() : b)};
          end
        end
        if ($urandom_range(99) < 90) txt = {txt, q};
      end else if (kind < 78) begin
        txt = {txt, CH_SLASH};
        txt = {txt, CH_SLASH};
        len = $urandom_range(0, 5);
        repeat (len) begin
          b = 8'($urandom_range(255));
          txt = {txt, (b == CH_LF ? letter() : b)};
        end
        if ($urandom_range(99) < 85) txt = {txt, CH_LF};
      end else if (kind < 92) begin
        txt = {txt, CH_SLASH};
        txt = {txt, CH_STAR};
        len = $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(3))
            0:       txt = {txt, CH_STAR};
            1:       txt = {txt, CH_SLASH};
            default: txt = {txt, 8'($urandom_range(255))};
          endcase
        end
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(3) == 0) txt = {txt, CH_STAR};
          txt = {txt, CH_STAR};
          txt = {txt, CH_SLASH};
        end
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) txt = {txt, 8'($urandom_range(255))};
      end
    end
    foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1);
    count += txt.size();
  endtask

  // Hold off new stimulus until every queued byte is taken and every result is back.
  task automatic wait_for_drain();
    do @(posedge clk);
    while (accepted_cnt != queued_cnt || sb.pending() != 0);
  endtask

  task automatic drive_text();
    src_byte_t nxt;
    text_ch.valid   = 1'b0;
    text_ch.in_byte = 8'h00;
    text_ch.in_last = 1'b0;
    forever begin
      @(posedge clk);
      if (text_ch.valid && text_ch.ready) begin
        sb.note_byte(text_ch.in_byte, text_ch.in_last);
        accepted_cnt++;
      end
      if (rst) begin
        text_ch.valid <= 1'b0;
      end else if (!text_ch.valid || text_ch.ready) begin
        if (src_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = src_q.pop_front();
          text_ch.valid   <= 1'b1;
          text_ch.in_byte <= nxt.ch;
          text_ch.in_last <= nxt.last;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic take_results();
    int hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        sb.check_result('{out_byte: result_ch.out_byte, byte_valid: result_ch.byte_valid,
                          out_last: result_ch.out_last, error: result_ch.error});
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        // long hold so the result queue fills and the input stalls
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  endtask

  initial drive_text();
  initial take_results();

  // Ends the run when no transfer happens on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int sent;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed texts: extremes, bare end marker, held slash, open comments and quotes
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_text(" ");
    queue_text("/");
    queue_text("/*");
    queue_text("/*/");
    queue_text("a/b");
    queue_text("'\\''");
    queue_text("\"a");
    queue_text("//");
    queue_byte(CH_TAB, 1'b0);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(8'h71, 1'b1);
    wait_for_drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 82;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 82;
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_BYTES / PHASES) queue_random_text(sent);
      wait_for_drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[comment_whitespace_stripper.f]
hw/rtl/cws_pkg.sv
hw/rtl/cws_text_if.sv
hw/rtl/cws_result_if.sv
hw/rtl/cws_lexer.sv
hw/rtl/cws_out_queue.sv
hw/rtl/comment_whitespace_stripper.sv
verif/tb_top.sv
